// ----- rtl/implicant_chart_cover_check_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the implicant chart cover check
// Clocked property wrappers with an active-low reset guard.
// ----------------------------------------------------------------------------
`ifndef IMPLICANT_CHART_COVER_CHECK_TOP_ASSERT_SVH
`define IMPLICANT_CHART_COVER_CHECK_TOP_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define ICC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define ICC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ICC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define ICC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ----- rtl/icc_pkg.sv -----
// ----------------------------------------------------------------------------
// icc_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package icc_pkg;

    // chart geometry
    localparam int MAX_IMPLICANTS = 256;
    localparam int MAX_COLUMNS    = 64;
    localparam int ADDR_W         = $clog2(MAX_IMPLICANTS);

    // item field widths
    localparam int IDX_W     = 8;
    localparam int ROW_W     = 64;
    localparam int COL_W     = 7;
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 8;

    // reset value of columns_in_use
    localparam logic [COL_W-1:0] COLS_RESET = COL_W'(64);

    // op codes carried on tuser
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    // controller -> datapath commands
    typedef struct packed {
        logic wr_row;    // write chart row from the input item
        logic rd_row;    // start chart read, latch last mark and range
        logic acc_row;   // OR read row into coverage
        logic fin_row;   // OR read row, issue result, clear coverage
        logic fin_cov;   // issue result from coverage, clear coverage
    } icc_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic op_check;  // input item is a check item
        logic last_pend; // check item in flight carries the last mark
        logic out_free;  // output register can take a result this cycle
    } icc_status_t;

endpackage

`default_nettype wire

// ----- rtl/implicant_chart_cover_check_top.sv -----
// ----------------------------------------------------------------------------
// implicant_chart_cover_check_top
// Row write items: accepted every cycle while idle, written to the chart at acceptance.
// Check items: registered chart read, then OR into coverage, before another item is taken;
// a last-marked item's result then goes to the result register, via S_WAIT if it is full.
// Result register decouples the output; a full register stalls only the end.
// Synchronous active-low reset clears coverage, control and columns to 64;
// chart contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module implicant_chart_cover_check_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // input items
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [icc_pkg::S_TDATA_W-1:0] s_tdata,  // [7:0] implicant_index, [71:8] row_bits
    input  wire logic [0:0]                    s_tuser,  // [0] op
    input  wire logic                          s_tlast,  // last
    // result items
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [icc_pkg::M_TDATA_W-1:0]      m_tdata,  // [0] covered, [7:1] zero
    // columns_in_use write
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [icc_pkg::COL_W-1:0]     cfg_data
);

    icc_pkg::icc_cmd_t    cmd;
    icc_pkg::icc_status_t status;

    // sequencer
    icc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // chart, accumulator and result
    icc_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser[0]),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire

// ----- rtl/icc_ram.sv -----
// ----------------------------------------------------------------------------
// icc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module icc_ram #(
    parameter  int WIDTH  = 64,
    parameter  int DEPTH  = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/icc_ctrl.sv -----
// ----------------------------------------------------------------------------
// icc_ctrl
// Sequencer: takes items, steps chart reads and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

`include "implicant_chart_cover_check_top_assert.svh"

module icc_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire icc_pkg::icc_status_t status,
    output icc_pkg::icc_cmd_t        cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_ACC  = 3'b010,
        S_WAIT = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (status.op_check == icc_pkg::OP_CHECK) begin
                        cmd.rd_row = 1'b1;
                        state_next = S_ACC;
                    end else begin
                        cmd.wr_row = 1'b1;
                    end
                end
            end
            S_ACC: begin
                if (status.last_pend && status.out_free) begin
                    cmd.fin_row = 1'b1;
                    state_next  = S_IDLE;
                end else if (status.last_pend) begin
                    // result register still occupied: park the coverage
                    cmd.acc_row = 1'b1;
                    state_next  = S_WAIT;
                end else begin
                    cmd.acc_row = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_WAIT: begin
                if (status.out_free) begin
                    cmd.fin_cov = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // checks
    `ICC_ASSERT_NXT(a_rd_to_acc, aclk, aresetn, cmd.rd_row, state_reg == S_ACC, "read not followed by accumulate")
    `ICC_ASSERT_IMP(a_busy_no_take, aclk, aresetn, state_reg != S_IDLE, !s_tready, "item taken while busy")
    `ICC_ASSERT_NXT(a_wait_leaves, aclk, aresetn, (state_reg == S_WAIT) && status.out_free, state_reg == S_IDLE, "wait state stuck with free output")

endmodule

`default_nettype wire

// ----- rtl/icc_dp.sv -----
// ----------------------------------------------------------------------------
// icc_dp
// Datapath: chart memory, coverage accumulator, column mask and result reg.
// ----------------------------------------------------------------------------
`default_nettype none

`include "implicant_chart_cover_check_top_assert.svh"

module icc_dp (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // input item payload
    input  wire logic [icc_pkg::S_TDATA_W-1:0]      s_tdata,
    input  wire logic                               s_tuser,
    input  wire logic                               s_tlast,
    // result channel
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [icc_pkg::M_TDATA_W-1:0]           m_tdata,
    // configuration
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [icc_pkg::COL_W-1:0]          cfg_data,
    // controller link
    input  wire icc_pkg::icc_cmd_t                  cmd,
    output icc_pkg::icc_status_t                    status
);

    logic [icc_pkg::IDX_W-1:0]  idx;
    logic [icc_pkg::ROW_W-1:0]  row_in;
    logic [icc_pkg::ADDR_W-1:0] addr;
    logic                       idx_ok;
    logic [icc_pkg::ROW_W-1:0]  rdata;
    logic [icc_pkg::ROW_W-1:0]  row_sel;
    logic [icc_pkg::ROW_W-1:0]  cov_sum;
    logic [icc_pkg::ROW_W-1:0]  cov_src;
    logic [icc_pkg::ROW_W-1:0]  need;
    logic [icc_pkg::COL_W-1:0]  cols_eff;
    logic                       covered;
    logic                       fin;
    logic                       out_free;

    logic [icc_pkg::ROW_W-1:0]  cov_reg, cov_next;
    logic [icc_pkg::COL_W-1:0]  cols_reg;
    logic                       last_reg;
    logic                       in_range_reg;
    logic                       m_valid_reg;
    logic                       covered_reg;

    // unpack item: implicant_index low, row_bits above
    assign idx    = s_tdata[icc_pkg::IDX_W-1:0];
    assign row_in = s_tdata[icc_pkg::IDX_W +: icc_pkg::ROW_W];
    assign addr   = icc_pkg::ADDR_W'(idx);
    assign idx_ok = 32'(idx) < icc_pkg::MAX_IMPLICANTS;

    // chart store
    icc_ram #(
        .WIDTH (icc_pkg::ROW_W),
        .DEPTH (icc_pkg::MAX_IMPLICANTS)
    ) u_chart (
        .aclk  (aclk),
        .we    (cmd.wr_row && idx_ok),
        .waddr (addr),
        .wdata (row_in),
        .re    (cmd.rd_row),
        .raddr (addr),
        .rdata (rdata)
    );

    // latch last mark and range of the check item in flight
    always_ff @(posedge aclk) begin
        if (cmd.rd_row) begin
            last_reg     <= s_tlast;
            in_range_reg <= idx_ok;
        end
    end

    // out-of-range selection adds nothing
    assign row_sel = in_range_reg ? rdata : '0;
    assign cov_sum = cov_reg | row_sel;
    assign fin     = cmd.fin_row || cmd.fin_cov;

    // coverage accumulator
    always_comb begin
        cov_next = cov_reg;
        if (fin) begin
            cov_next = '0;
        end else if (cmd.acc_row) begin
            cov_next = cov_sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cov_reg <= '0;
        end else begin
            cov_reg <= cov_next;
        end
    end

    // columns_in_use register, saturated to chart width on use
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg <= icc_pkg::COLS_RESET;
        end else if (cfg_valid) begin
            cols_reg <= cfg_data;
        end
    end

    assign cols_eff = (cols_reg > icc_pkg::COL_W'(icc_pkg::MAX_COLUMNS)) ?
                      icc_pkg::COL_W'(icc_pkg::MAX_COLUMNS) : cols_reg;

    // columns that need a cover bit
    always_comb begin
        for (int k = 0; k < icc_pkg::ROW_W; k++) begin
            need[k] = icc_pkg::COL_W'(k) < cols_eff;
        end
    end

    assign cov_src = cmd.fin_row ? cov_sum : cov_reg;
    assign covered = &(cov_src | ~need);

    // result register
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fin) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fin) begin
            covered_reg <= covered;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(icc_pkg::M_TDATA_W-1){1'b0}}, covered_reg};

    // status back to the sequencer
    assign status.op_check  = s_tuser;
    assign status.last_pend = last_reg;
    assign status.out_free  = out_free;

    // checks
    `ICC_ASSERT_IMP(a_fin_free, aclk, aresetn, fin, out_free, "result loaded over a pending result")
    `ICC_ASSERT_NXT(a_fin_clear, aclk, aresetn, fin, (cov_reg == '0) && m_valid_reg, "coverage not cleared on result")
    `ICC_ASSERT_IMP(a_rw_excl, aclk, aresetn, cmd.wr_row, !cmd.rd_row && !fin, "chart write overlaps check work")

endmodule

`default_nettype wire
